/* hdl/fec_pkg.sv */
// Package for the filename escape codec: character constants, register
// indexes, the result slot type and the escape code tables.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package fec_pkg;

   localparam int unsigned CHAR_W = 8;

   typedef logic [CHAR_W-1:0] char_type;

   typedef struct packed {
      char_type data;
      logic     last;
   } slot_type;

   // Configuration register indexes.
   localparam logic REG_DIRECTION = 1'b0;
   localparam logic REG_ESCAPING  = 1'b1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam char_type CH_NONE       = 8'h00;
   localparam char_type CH_UNDERSCORE = 8'h5F;
   localparam char_type CH_LT         = 8'h3C;
   localparam char_type CH_GT         = 8'h3E;
   localparam char_type CH_PIPE       = 8'h7C;
   localparam char_type CH_QUOTE      = 8'h22;
   localparam char_type CH_BACKSLASH  = 8'h5C;
   localparam char_type CH_SLASH      = 8'h2F;
   localparam char_type CH_COLON      = 8'h3A;
   localparam char_type CH_STAR       = 8'h2A;
   localparam char_type CH_QUESTION   = 8'h3F;

   localparam char_type CODE_L = 8'h4C;
   localparam char_type CODE_G = 8'h47;
   localparam char_type CODE_P = 8'h50;
   localparam char_type CODE_U = 8'h55;
   localparam char_type CODE_S = 8'h53;
   localparam char_type CODE_B = 8'h42;
   localparam char_type CODE_F = 8'h46;
   localparam char_type CODE_C = 8'h43;
   localparam char_type CODE_A = 8'h41;
   localparam char_type CODE_Q = 8'h51;

   // Code letter for a reserved character, CH_NONE when it is not reserved.
   function automatic char_type code_of(input char_type c);
      char_type r;
      case (c)
         CH_LT:         r = CODE_L;
         CH_GT:         r = CODE_G;
         CH_PIPE:       r = CODE_P;
         CH_UNDERSCORE: r = CODE_U;
         CH_QUOTE:      r = CODE_S;
         CH_BACKSLASH:  r = CODE_B;
         CH_SLASH:      r = CODE_F;
         CH_COLON:      r = CODE_C;
         CH_STAR:       r = CODE_A;
         CH_QUESTION:   r = CODE_Q;
         default:       r = CH_NONE;
      endcase
      return r;
   endfunction

   // Reserved character for a code letter, CH_NONE when the letter is unknown.
   function automatic char_type char_of(input char_type c);
      char_type r;
      case (c)
         CODE_L:  r = CH_LT;
         CODE_G:  r = CH_GT;
         CODE_P:  r = CH_PIPE;
         CODE_U:  r = CH_UNDERSCORE;
         CODE_S:  r = CH_QUOTE;
         CODE_B:  r = CH_BACKSLASH;
         CODE_F:  r = CH_SLASH;
         CODE_C:  r = CH_COLON;
         CODE_A:  r = CH_STAR;
         CODE_Q:  r = CH_QUESTION;
         default: r = CH_NONE;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/fec_channels_if.sv */
// Valid/ready channel interfaces of the filename escape codec: one for
// incoming name bytes and one for converted bytes. Depends on fec_pkg.
`default_nettype none

interface fec_req_if;
   logic              valid;
   logic              ready;
   fec_pkg::char_type in_byte;
   logic              in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface fec_rsp_if;
   logic              valid;
   logic              ready;
   fec_pkg::char_type out_byte;
   logic              out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

/* hdl/filename_escape_codec.sv */
// Top level of the filename escape codec: escape/unescape of name bytes.
// Depends on fec_pkg and the channel interfaces in fec_channels_if.sv.
//
// Each name byte is converted in the cycle it is accepted and its results are
// written into a two-slot result buffer; the first slot drives the result
// port. A byte that yields at most one result is taken every cycle while the
// result side keeps up; its result is shown in the cycle after its transfer
// in. A byte that yields two results fills both slots; no new byte is taken
// until the second result is popped. With escaping off, encoding turns
// backslash into slash. Configuration is read directly and should only change
// while the block is idle; the decoder's held-back underscore survives a write.
`default_nettype none

module filename_escape_codec (
   input  wire       clock,
   input  wire       reset,
   fec_req_if.sink   req_if,
   fec_rsp_if.source rsp_if,
   input  wire       csr_wr_en,
   input  wire       csr_index,
   input  wire       csr_wdata
);

   logic                direction_ff, direction_in;
   logic                escaping_ff, escaping_in;
   logic                pending_ff, pending_in;
   logic                pri_valid_ff, pri_valid_in;
   logic                sec_valid_ff, sec_valid_in;
   fec_pkg::slot_type   pri_ff, pri_in;
   fec_pkg::slot_type   sec_ff, sec_in;

   logic                accept;
   logic                pop;
   logic [1:0]          res_count;
   fec_pkg::slot_type   res0, res1;
   logic                res_pending;
   fec_pkg::char_type   c;
   fec_pkg::char_type   code;
   fec_pkg::char_type   plain;
   logic                last;

   assign pop    = pri_valid_ff && rsp_if.ready;
   // Room for two results once the head slot drains this cycle.
   assign req_if.ready = !sec_valid_ff && (!pri_valid_ff || rsp_if.ready);
   assign accept = req_if.valid && req_if.ready;

   assign rsp_if.valid    = pri_valid_ff;
   assign rsp_if.out_byte = pri_ff.data;
   assign rsp_if.out_last = pri_ff.last;

   always_comb begin
      direction_in = direction_ff;
      escaping_in  = escaping_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fec_pkg::REG_DIRECTION: direction_in = csr_wdata;
            fec_pkg::REG_ESCAPING:  escaping_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Conversion of one byte into up to two results.
   always_comb begin
      c           = req_if.in_byte;
      last        = req_if.in_last;
      res_count   = 2'd1;
      res0        = '{data: c, last: last};
      res1        = '{data: c, last: last};
      res_pending = 1'b0;
      code        = fec_pkg::code_of(c);
      plain       = fec_pkg::char_of(c);
      if (direction_ff == fec_pkg::DIR_DECODE && escaping_ff) begin
         if (pending_ff && plain != fec_pkg::CH_NONE) begin
            res0 = '{data: plain, last: last};
         end else if (pending_ff) begin
            // The held underscore was not an escape; send it and treat the byte as new.
            res0 = '{data: fec_pkg::CH_UNDERSCORE, last: 1'b0};
            if (c == fec_pkg::CH_UNDERSCORE && !last) begin
               res_pending = 1'b1;
            end else begin
               res_count = 2'd2;
            end
         end else if (c == fec_pkg::CH_UNDERSCORE && !last) begin
            res_count   = 2'd0;
            res_pending = 1'b1;
         end
      end else if (direction_ff == fec_pkg::DIR_ENCODE && escaping_ff) begin
         if (code != fec_pkg::CH_NONE) begin
            res0      = '{data: fec_pkg::CH_UNDERSCORE, last: 1'b0};
            res1      = '{data: code, last: last};
            res_count = 2'd2;
         end
      end else if (direction_ff == fec_pkg::DIR_ENCODE) begin
         if (c == fec_pkg::CH_BACKSLASH) begin
            res0 = '{data: fec_pkg::CH_SLASH, last: last};
         end
      end
   end

   always_comb begin
      pending_in   = pending_ff;
      pri_valid_in = pri_valid_ff;
      sec_valid_in = sec_valid_ff;
      pri_in       = pri_ff;
      sec_in       = sec_ff;
      if (pop) begin
         pri_valid_in = sec_valid_ff;
         pri_in       = sec_ff;
         sec_valid_in = 1'b0;
      end
      if (accept) begin
         pending_in   = res_pending;
         pri_valid_in = (res_count != 2'd0);
         sec_valid_in = (res_count == 2'd2);
         pri_in       = res0;
         sec_in       = res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= fec_pkg::DIR_ENCODE;
         escaping_ff  <= 1'b1;
         pending_ff   <= 1'b0;
         pri_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         escaping_ff  <= escaping_in;
         pending_ff   <= pending_in;
         pri_valid_ff <= pri_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pri_ff <= pri_in;
      sec_ff <= sec_in;
   end

endmodule

`default_nettype wire
